FILE: src/sitda_pkg.sv
package sitda_pkg;

    // Width of one packed BCD digit.
    localparam int DIGIT_W = 4;

    // ASCII codes that the block emits.
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Which character the datapath loads into its output register.
    typedef enum logic [1:0] {
        SEL_MINUS   = 2'd0,
        SEL_DIGIT   = 2'd1,
        SEL_NEWLINE = 2'd2
    } char_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;        // capture a new number and clear the BCD digits
        logic      dabble;      // one shift-add-3 step of the binary to BCD conversion
        logic      shift_digit; // drop the leading BCD digit
        logic      emit;        // load a character into the output register
        char_sel_t char_sel;
    } sitda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic neg;      // the captured number is negative
        logic top_zero; // the leading BCD digit is zero
        logic out_free; // the output register can take a character this cycle
    } sitda_status_t;

endpackage

FILE: src/sitda_datapath.sv
module sitda_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] number_in,
    input  sitda_pkg::sitda_cmd_t         cmd,
    output sitda_pkg::sitda_status_t      status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_out,
    output logic                          last_char
);

    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 1234) / 4096 + 1;
    localparam int BCD_W      = NUM_DIGITS * sitda_pkg::DIGIT_W;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;

    logic [VALUE_WIDTH-1:0] abs_value;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    assign abs_value = number_in[VALUE_WIDTH-1] ? (~number_in + 1'b1) : number_in;
    assign top_digit = bcd_reg[BCD_W-1 -: sitda_pkg::DIGIT_W];

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        if (cmd.load)
        begin
            mag_next = abs_value;
            bcd_next = '0;
            neg_next = number_in[VALUE_WIDTH-1];
        end
        else if (cmd.dabble)
        begin
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
        end
        else if (cmd.shift_digit)
        begin
            bcd_next = bcd_reg << sitda_pkg::DIGIT_W;
        end
    end

    always_comb
    begin
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.emit)
        begin
            case (cmd.char_sel)
                sitda_pkg::SEL_MINUS:
                begin
                    char_next = sitda_pkg::CHAR_MINUS;
                    last_next = 1'b0;
                end
                sitda_pkg::SEL_DIGIT:
                begin
                    char_next = sitda_pkg::CHAR_ZERO + {4'b0000, top_digit};
                    last_next = 1'b0;
                end
                sitda_pkg::SEL_NEWLINE:
                begin
                    char_next = sitda_pkg::CHAR_NEWLINE;
                    last_next = 1'b1;
                end
                default:
                begin
                    char_next = sitda_pkg::CHAR_NEWLINE;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    assign valid_next = cmd.emit | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg      = neg_reg;
    assign status.top_zero = (top_digit == 4'd0);
    assign status.out_free = ~valid_reg | ~out_stall;

    assign out_valid = valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

    // A new character is loaded only when the output register can take it.
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("character loaded over a waiting transfer");

    // The closing flag sits on the newline and nowhere else.
    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char |-> char_out == sitda_pkg::CHAR_NEWLINE)
        else $error("last flag on a character that is not newline");

    // Every other character is a minus sign or a decimal digit.
    a_body_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_char |->
            char_out == sitda_pkg::CHAR_MINUS ||
            (char_out >= sitda_pkg::CHAR_ZERO && char_out <= sitda_pkg::CHAR_ZERO + 8'd9))
        else $error("illegal character in the digit run");

endmodule

FILE: src/sitda_ctrl.sv
module sitda_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sitda_pkg::sitda_status_t status,
    output sitda_pkg::sitda_cmd_t    cmd
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 1234) / 4096 + 1;
    localparam int BIT_CW     = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CW     = $clog2(NUM_DIGITS + 1);
    localparam logic [BIT_CW-1:0] BIT_INIT = BIT_CW'(VALUE_WIDTH);
    localparam logic [DIG_CW-1:0] DIG_INIT = DIG_CW'(NUM_DIGITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_SKIP  = 6'b000100,
        S_SIGN  = 6'b001000,
        S_DIGIT = 6'b010000,
        S_NL    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [BIT_CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0] dig_cnt_reg, dig_cnt_next;

    always_comb
    begin
        state_next      = state_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        cmd.load        = 1'b0;
        cmd.dabble      = 1'b0;
        cmd.shift_digit = 1'b0;
        cmd.emit        = 1'b0;
        cmd.char_sel    = sitda_pkg::SEL_DIGIT;
        in_stall        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_INIT;
                    dig_cnt_next = DIG_INIT;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CW'(1))
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (status.top_zero && dig_cnt_reg != DIG_CW'(1))
                begin
                    cmd.shift_digit = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                end
                else if (status.neg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = sitda_pkg::SEL_MINUS;
                    state_next   = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.char_sel    = sitda_pkg::SEL_DIGIT;
                    cmd.shift_digit = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CW'(1))
                    begin
                        state_next = S_NL;
                    end
                end
            end
            S_NL:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = sitda_pkg::SEL_NEWLINE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    // After a transfer on the input the block holds off until the run is out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second input taken while a number is in conversion");

    // The conversion always ends with its full bit count spent.
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV && state_next == S_SKIP |-> bit_cnt_reg == BIT_CW'(1))
        else $error("conversion left before all bits were shifted in");

    // The newline follows only after the last digit has gone out.
    a_digits_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_NL) |-> dig_cnt_reg == '0)
        else $error("newline reached with digits left");

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// The first character is loaded once the conversion and the leading-zero skip are done;
// the digit capacity is 10 at the default width.
// A new number is taken only once the newline of the last one enters the output register,
// and a minus sign adds the sign state to the run; a stalled output holds the run.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and empties
// the output register; there is no other state to clear.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel: one signed integer per transfer.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] number_in,
    // Output channel: one ASCII character per transfer.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_out,
    output logic                          last_char
);

    // The conversion is a bit-serial double dabble: the magnitude is shifted into a
    // packed BCD register one bit per cycle, with every digit of five or more first
    // raised by three. The bit loop over all VALUE_WIDTH bits is what sets the rate.
    //
    // Leading zeros are then dropped one digit per cycle by shifting the BCD register
    // left until its leading digit is nonzero or only one digit is left, so zero still
    // prints as a single '0'. The sign, the digits and the closing newline then leave
    // through a single output register, one character per transfer. The magnitude is
    // taken as an unsigned VALUE_WIDTH-bit number, so the most negative value prints
    // correctly.
    //
    // The block takes a new number only while the controller is idle; the controller
    // returns there on the cycle the newline enters the output register, so the next
    // number can start while the newline still waits to be taken.

    sitda_pkg::sitda_cmd_t    cmd;
    sitda_pkg::sitda_status_t status;

    sitda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sitda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .number_in (number_in),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last_char (last_char)
    );

endmodule
